// ===== src/equalizer_band_count_mapper_core_macros.svh =====
// Assertion helpers for the band count mapper. Both sample on clk_i and are
// disabled while rst_ni is low.
`ifndef EQUALIZER_BAND_COUNT_MAPPER_CORE_MACROS_SVH
`define EQUALIZER_BAND_COUNT_MAPPER_CORE_MACROS_SVH

// cons must hold in the same cycle as ante
`define EBCM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define EBCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ebcm_pkg.sv =====
`default_nettype none

package ebcm_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned TB_W      = 7;   // target_bands register
  localparam int unsigned BIDX_W    = 6;   // band_index
  localparam int unsigned STEP_W    = 7;   // loop indexes and counts, up to 64
  localparam int unsigned ACC_W     = 8;   // signed error accumulator
  localparam int unsigned GRP_W     = 7;   // group size, divisor
  localparam int unsigned SUM_W     = LEVEL_W + GRP_W;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W + 1);

  localparam int unsigned DEF_MAX_SOURCE_BANDS = 8;
  localparam int unsigned DEF_MAX_TARGETS      = 64;

  localparam logic [TB_W-1:0] TARGET_BANDS_RESET = 7'd5;

  // register indexes
  localparam logic REG_TARGET_BANDS = 1'b0;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level;
    logic                      last_band;
  } in_item_t;

  typedef struct packed {
    logic [BIDX_W-1:0]         band_index;
    logic signed [LEVEL_W-1:0] band_level;
    logic                      last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_ADD,
    S_DIV,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== src/equalizer_band_count_mapper_core.sv =====
// Equalizer band count mapper. Source band levels come in one item at a time
// and are stored (up to MAX_SOURCE_BANDS; extra levels are dropped). A non-last
// item is simply stored. The item with last_band set starts a run that
// emits exactly T = target_bands results (0 is treated as 1, values above
// MAX_TARGETS saturate), either spreading the levels over the targets or
// averaging groups of them. Every result goes through one shared restoring
// divider that retires one quotient bit per cycle, so a result takes a read,
// an accumulate, 23 divide steps and an output step, plus an add step when
// two levels are averaged. In a grouping run every stored level also costs a
// read and an accumulate step. Output stalls lengthen both kinds of run.
// in_ready_o stays low for the whole run.
// target_bands is written over the APB port at address 0 and should only
// change while the block is idle.
`default_nettype none

`include "equalizer_band_count_mapper_core_macros.svh"

module equalizer_band_count_mapper_core #(
  parameter int unsigned MAX_SOURCE_BANDS = ebcm_pkg::DEF_MAX_SOURCE_BANDS,
  parameter int unsigned MAX_TARGETS      = ebcm_pkg::DEF_MAX_TARGETS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ebcm_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ebcm_pkg::out_item_t     out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import ebcm_pkg::*;

  localparam int unsigned IDX_W = (MAX_SOURCE_BANDS > 1) ? $clog2(MAX_SOURCE_BANDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SOURCE_BANDS + 1);

  // configuration
  logic [TB_W-1:0] tb_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TARGET_BANDS) ? {{(32-TB_W){1'b0}}, tb_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q <= TARGET_BANDS_RESET;
    end else if (cfg_wr && paddr[2] == REG_TARGET_BANDS) begin
      tb_q <= pwdata[TB_W-1:0];
    end
  end

  // effective target count
  logic [TB_W-1:0] t_eff;
  always_comb begin
    if (tb_q == '0) begin
      t_eff = TB_W'(1);
    end else if (tb_q > TB_W'(MAX_TARGETS)) begin
      t_eff = TB_W'(MAX_TARGETS);
    end else begin
      t_eff = tb_q;
    end
  end

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // run state (payload)
  logic [STEP_W-1:0]       n_q, n_d;
  logic [TB_W-1:0]         t_q, t_d;
  logic                    spread_q, spread_d;   // N <= T
  logic [STEP_W-1:0]       i_q, i_d;
  logic [STEP_W-1:0]       src_q, src_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [GRP_W-1:0]        grp_q, grp_d;
  logic [BIDX_W-1:0]       ridx_q, ridx_d;
  out_item_t               out_q, out_d;

  // level memory
  logic signed [LEVEL_W-1:0] mem [MAX_SOURCE_BANDS];
  logic signed [LEVEL_W-1:0] rdata_q;
  logic [IDX_W-1:0]          raddr;

  // shared divider
  logic                    div_load;
  logic signed [SUM_W-1:0] div_num;
  logic [GRP_W-1:0]        div_den;
  logic [GRP_W-1:0]        div_den_q, div_den_d;
  logic [GRP_W-1:0]        div_rem_q, div_rem_d;
  logic [SUM_W-1:0]        div_quo_q, div_quo_d;
  logic                    div_neg_q, div_neg_d;
  logic [DIV_CNT_W-1:0]    div_cnt_q, div_cnt_d;

  logic in_acc;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (in_acc && cnt_q < CNT_W'(MAX_SOURCE_BANDS)) begin
      mem[cnt_q[IDX_W-1:0]] <= in_item_i.level;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    logic [STEP_W-1:0]       rd_sel;
    logic [STEP_W-1:0]       src_nx;
    logic [STEP_W-1:0]       n_new;
    logic signed [ACC_W-1:0] a1;
    logic signed [SUM_W-1:0] lvl_ext;
    logic [LEVEL_W-1:0]      qlo;
    logic                    is_last;

    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    n_d         = n_q;
    t_d         = t_q;
    spread_d    = spread_q;
    i_d         = i_q;
    src_d       = src_q;
    acc_d       = acc_q;
    sum_d       = sum_q;
    grp_d       = grp_q;
    ridx_d      = ridx_q;
    out_d       = out_q;
    div_load    = 1'b0;
    div_num     = '0;
    div_den     = '0;

    src_nx  = src_q + STEP_W'(1);
    lvl_ext = SUM_W'(rdata_q);
    a1      = spread_q ? acc_q - $signed({1'b0, n_q}) : acc_q - $signed({1'b0, t_q});
    qlo     = div_quo_q[LEVEL_W-1:0];
    is_last = ({1'b0, ridx_q} == t_q - TB_W'(1));

    // read address: source index in group mode, clamped cursor in spread mode
    if (!spread_q) begin
      rd_sel = i_q;
    end else if (state_q == S_ACC) begin
      rd_sel = (src_nx >= n_q) ? n_q - STEP_W'(1) : src_nx;
    end else begin
      rd_sel = (src_q >= n_q) ? n_q - STEP_W'(1) : src_q;
    end
    raddr = rd_sel[IDX_W-1:0];

    n_new = (cnt_q < CNT_W'(MAX_SOURCE_BANDS)) ? STEP_W'(cnt_q) + STEP_W'(1)
                                               : STEP_W'(cnt_q);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q < CNT_W'(MAX_SOURCE_BANDS)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (in_item_i.last_band) begin
            cnt_d    = '0;
            n_d      = n_new;
            t_d      = t_eff;
            spread_d = (n_new <= STEP_W'(t_eff));
            i_d      = '0;
            src_d    = '0;
            acc_d    = (n_new <= STEP_W'(t_eff)) ? $signed({1'b0, t_eff})
                                                 : $signed({1'b0, n_new});
            sum_d    = '0;
            grp_d    = '0;
            ridx_d   = '0;
            state_d  = S_READ;
          end
        end
      end

      S_READ: begin
        state_d = S_ACC;
      end

      S_ACC: begin
        if (spread_q) begin
          acc_d = a1;
          if (a1 < ACC_W'(1)) begin
            src_d = src_nx;
            acc_d = a1 + $signed({1'b0, t_q});
          end
          if (a1 < ACC_W'(0)) begin
            // average with the next level, read issued this cycle
            sum_d   = lvl_ext;
            state_d = S_ADD;
          end else begin
            div_load = 1'b1;
            div_num  = lvl_ext;
            div_den  = GRP_W'(1);
            state_d  = S_DIV;
          end
        end else begin
          if (a1 < ACC_W'(1)) begin
            div_load = 1'b1;
            div_num  = sum_q + lvl_ext;
            div_den  = grp_q + GRP_W'(1);
            acc_d    = a1 + $signed({1'b0, n_q});
            // a straddling band also opens the next group
            if (a1 < ACC_W'(0)) begin
              sum_d = lvl_ext;
              grp_d = GRP_W'(1);
            end else begin
              sum_d = '0;
              grp_d = '0;
            end
            state_d = S_DIV;
          end else begin
            acc_d   = a1;
            sum_d   = sum_q + lvl_ext;
            grp_d   = grp_q + GRP_W'(1);
            i_d     = i_q + STEP_W'(1);
            state_d = S_READ;
          end
        end
      end

      S_ADD: begin
        div_load = 1'b1;
        div_num  = sum_q + lvl_ext;
        div_den  = GRP_W'(2);
        state_d  = S_DIV;
      end

      S_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(1)) begin
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.band_index  = ridx_q;
          out_d.band_level  = div_neg_q ? $signed(~qlo + LEVEL_W'(1)) : $signed(qlo);
          out_d.last_result = is_last;
          ridx_d            = ridx_q + BIDX_W'(1);
          i_d               = i_q + STEP_W'(1);
          state_d           = is_last ? S_IDLE : S_READ;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // restoring divide on magnitudes, one quotient bit per cycle
  always_comb begin
    logic [GRP_W:0] trial;
    logic           ge;

    trial     = {div_rem_q, div_quo_q[SUM_W-1]};
    ge        = (trial >= {1'b0, div_den_q});
    div_den_d = div_den_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_neg_d = div_neg_q;
    div_cnt_d = div_cnt_q;

    if (div_load) begin
      div_den_d = div_den;
      div_rem_d = '0;
      div_neg_d = div_num[SUM_W-1];
      div_quo_d = div_num[SUM_W-1] ? SUM_W'(-div_num) : SUM_W'(div_num);
      div_cnt_d = DIV_CNT_W'(SUM_W);
    end else if (state_q == S_DIV) begin
      div_rem_d = ge ? GRP_W'(trial - {1'b0, div_den_q}) : trial[GRP_W-1:0];
      div_quo_d = {div_quo_q[SUM_W-2:0], ge};
      div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    t_q       <= t_d;
    spread_q  <= spread_d;
    i_q       <= i_d;
    src_q     <= src_d;
    acc_q     <= acc_d;
    sum_q     <= sum_d;
    grp_q     <= grp_d;
    ridx_q    <= ridx_d;
    out_q     <= out_d;
    div_den_q <= div_den_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_neg_q <= div_neg_d;
    div_cnt_q <= div_cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `EBCM_ASSERT_NEXT(a_last_item_starts_run, in_acc && in_item_i.last_band, !in_ready_o, "last item did not start a run")
  `EBCM_ASSERT_SAME(a_quotient_fits_level, state_q == S_OUT, div_quo_q[SUM_W-1:LEVEL_W] == '0, "quotient exceeds level width")
  `EBCM_ASSERT_SAME(a_run_has_bands, state_q != S_IDLE, n_q != '0 && t_q != '0, "run started with zero bands")

endmodule

`default_nettype wire
